@@ rtl/lgps_pkg.sv @@
// ----------------------------------------------------------------------------
// Linear gradient shader package
// Types, codes and constants shared by the linear gradient shader modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lgps_pkg;

  localparam int COEF_W   = 32;
  localparam int COLOR_W  = 32;
  localparam int SLOT_W   = 4;
  localparam int CHAN_W   = 8;
  localparam int WEIGHT_W = 16;
  localparam int LERP_W   = 24;
  localparam int PROD_W   = 2 * LERP_W;
  localparam int QUOT_W   = 17;
  localparam int CFG_AW   = 3;

  localparam logic [LERP_W-1:0] LERP_HALF   = 24'h00_8000;
  localparam logic [PROD_W:0]   PREMUL_BIAS = 49'h007F_8000_0000;

  typedef enum logic [CFG_AW-1:0] {
    CFG_COEF_A     = 3'd0,
    CFG_COEF_B     = 3'd1,
    CFG_COEF_C     = 3'd2,
    CFG_TILE_MODE  = 3'd3,
    CFG_STOP_COUNT = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    TILE_CLAMP  = 2'd0,
    TILE_REPEAT = 2'd1,
    TILE_MIRROR = 2'd2
  } tile_mode_t;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_SHADE = 1'b1
  } item_mode_t;

  typedef struct packed {
    logic valid;
    logic shade;
  } pipe_tag_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [COLOR_W-1:0] color;
  } stop_load_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic        [1:0]        tile_mode;
  } pos_cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } argb_t;

endpackage

`default_nettype wire

@@ rtl/lgps_position.sv @@
// ----------------------------------------------------------------------------
// Gradient position stages
// Maps the pixel centre to a gradient position and folds it by the tile mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgps_position
  import lgps_pkg::*;
#(
  parameter int COORD_BITS     = 12,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pos_cfg_t                  cfg,
  input  pipe_tag_t                 in_tag,
  input  stop_load_t                in_load,
  input  logic [COORD_BITS-1:0]     x_coord,
  input  logic [COORD_BITS-1:0]     y_coord,
  output logic                      up_en,
  input  logic                      down_en,
  output pipe_tag_t                 out_tag,
  output stop_load_t                out_load,
  output logic [COEF_FRAC_BITS:0]   out_frac
);

  localparam int XW = COORD_BITS + 1;
  localparam int PW = COEF_W + XW + 1;
  localparam int TW = PW + 2;
  localparam int FB = COEF_FRAC_BITS + 1;

  pipe_tag_t            s1_tag_r, s2_tag_r, s3_tag_r;
  stop_load_t           s1_load_r, s2_load_r, s3_load_r;
  logic signed [PW-1:0] s1_prod_a_r, s1_prod_b_r, s1_prod_a_nxt, s1_prod_b_nxt;
  logic signed [TW-1:0] s2_pos_r, s2_pos_nxt;
  logic [FB-1:0]        s3_frac_r, s3_frac_nxt;
  logic [FB:0]          mir_fold, mir_refl;
  logic                 s1_en, s2_en, s3_en;

  assign s3_en = !s3_tag_r.valid || down_en;
  assign s2_en = !s2_tag_r.valid || s3_en;
  assign s1_en = !s1_tag_r.valid || s2_en;
  assign up_en = s1_en;

  always_comb begin
    s1_prod_a_nxt = $signed(cfg.coef_a) * $signed({1'b0, x_coord, 1'b1});
    s1_prod_b_nxt = $signed(cfg.coef_b) * $signed({1'b0, y_coord, 1'b1});
  end

  always_comb begin
    s2_pos_nxt = TW'(s1_prod_a_r) + TW'(s1_prod_b_r) + (TW'($signed(cfg.coef_c)) <<< 1);
  end

  always_comb begin
    mir_fold = s2_pos_r[FB:0];
    mir_refl = mir_fold[FB] ? (~mir_fold + 1'b1) : mir_fold;
    unique case (cfg.tile_mode)
      TILE_REPEAT: s3_frac_nxt = s2_pos_r[FB-1:0];
      TILE_MIRROR: s3_frac_nxt = mir_refl[FB] ? '1 : mir_refl[FB-1:0];
      default: begin
        if (s2_pos_r[TW-1]) begin
          s3_frac_nxt = '0;
        end else if (|s2_pos_r[TW-2:FB]) begin
          s3_frac_nxt = '1;
        end else begin
          s3_frac_nxt = s2_pos_r[FB-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      s3_tag_r <= '0;
    end else begin
      if (s1_en) begin
        s1_tag_r <= in_tag;
      end
      if (s2_en) begin
        s2_tag_r <= s1_tag_r;
      end
      if (s3_en) begin
        s3_tag_r <= s2_tag_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_load_r   <= in_load;
      s1_prod_a_r <= s1_prod_a_nxt;
      s1_prod_b_r <= s1_prod_b_nxt;
    end
    if (s2_en) begin
      s2_load_r <= s1_load_r;
      s2_pos_r  <= s2_pos_nxt;
    end
    if (s3_en) begin
      s3_load_r <= s2_load_r;
      s3_frac_r <= s3_frac_nxt;
    end
  end

  assign out_tag  = s3_tag_r;
  assign out_load = s3_load_r;
  assign out_frac = s3_frac_r;

endmodule

`default_nettype wire

@@ rtl/lgps_stops.sv @@
// ----------------------------------------------------------------------------
// Stop selection and colour table
// Scales the folded position by (stop count - 1) and reads two adjacent stops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgps_stops
  import lgps_pkg::*;
#(
  parameter int MAX_STOPS      = 16,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(MAX_STOPS)-1:0]  nm1,
  input  pipe_tag_t                     in_tag,
  input  stop_load_t                    in_load,
  input  logic [COEF_FRAC_BITS:0]       in_frac,
  output logic                          up_en,
  input  logic                          down_en,
  output logic                          out_valid,
  output argb_t                         out_c0,
  output argb_t                         out_c1,
  output logic [WEIGHT_W-1:0]           out_w,
  output logic                          out_single
);

  localparam int SW = $clog2(MAX_STOPS);
  localparam int FB = COEF_FRAC_BITS + 1;

  logic [COLOR_W-1:0] stop_mem [MAX_STOPS];

  pipe_tag_t           s4_tag_r;
  stop_load_t          s4_load_r;
  logic [SW-1:0]       s4_idx_r, s4_idx_nxt, s4_idx_up;
  logic [WEIGHT_W-1:0] s4_w_r, s4_w_nxt;
  logic                s4_single_r;
  logic [FB+SW-1:0]    s4_prod_nxt;
  logic                s5_valid_r;
  argb_t               s5_c0_r, s5_c1_r;
  logic [WEIGHT_W-1:0] s5_w_r;
  logic                s5_single_r;
  logic                s4_en, s5_en, stop_we;

  assign s5_en = !s5_valid_r || down_en;
  assign s4_en = !s4_tag_r.valid || s5_en;
  assign up_en = s4_en;

  always_comb begin
    s4_prod_nxt = (FB+SW)'(in_frac) * (FB+SW)'(nm1);
    s4_idx_nxt  = s4_prod_nxt[FB+SW-1:FB];
    s4_w_nxt    = s4_prod_nxt[FB-1:FB-WEIGHT_W];
  end

  assign s4_idx_up = SW'(s4_idx_r + 1'b1);
  assign stop_we   = s5_en && s4_tag_r.valid && !s4_tag_r.shade &&
                     (32'(s4_load_r.slot) < 32'(MAX_STOPS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_tag_r   <= '0;
      s5_valid_r <= 1'b0;
    end else begin
      if (s4_en) begin
        s4_tag_r <= in_tag;
      end
      if (s5_en) begin
        s5_valid_r <= s4_tag_r.valid && s4_tag_r.shade;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_load_r   <= in_load;
      s4_idx_r    <= s4_idx_nxt;
      s4_w_r      <= s4_w_nxt;
      s4_single_r <= (nm1 == '0);
    end
    if (s5_en) begin
      s5_w_r      <= s4_w_r;
      s5_single_r <= s4_single_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stop_we) begin
      stop_mem[SW'(s4_load_r.slot)] <= s4_load_r.color;
    end
    if (s5_en) begin
      s5_c0_r <= stop_mem[s4_idx_r];
      s5_c1_r <= stop_mem[s4_idx_up];
    end
  end

  assign out_valid  = s5_valid_r;
  assign out_c0     = s5_c0_r;
  assign out_c1     = s5_c1_r;
  assign out_w      = s5_w_r;
  assign out_single = s5_single_r;

endmodule

`default_nettype wire

@@ rtl/lgps_blend.sv @@
// ----------------------------------------------------------------------------
// Colour blend and output stages
// Interpolates the four channels, premultiplies by alpha and holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgps_blend
  import lgps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  argb_t               in_c0,
  input  argb_t               in_c1,
  input  logic [WEIGHT_W-1:0] in_w,
  input  logic                in_single,
  output logic                up_en,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata
);

  argb_t               c_hi;
  logic                s6_valid_r, s7_valid_r, out_valid_r;
  logic [LERP_W-1:0]   s6_va_r, s6_vr_r, s6_vg_r, s6_vb_r;
  logic [LERP_W-1:0]   s6_va_nxt, s6_vr_nxt, s6_vg_nxt, s6_vb_nxt, alpha_sum;
  logic [CHAN_W-1:0]   s7_alpha_r;
  logic [PROD_W-1:0]   s7_pr_r, s7_pg_r, s7_pb_r;
  logic [31:0]         out_data_r, out_data_nxt;
  logic                s6_en, s7_en, s8_en;

  function automatic logic [LERP_W-1:0] lerp(input logic [CHAN_W-1:0] lo,
                                              input logic [CHAN_W-1:0] hi,
                                              input logic [WEIGHT_W-1:0] w);
    logic signed [CHAN_W:0]  diff;
    logic signed [26:0]      delta;
    logic signed [26:0]      total;
    diff  = $signed({1'b0, hi}) - $signed({1'b0, lo});
    delta = diff * $signed({1'b0, w});
    total = $signed({3'b000, lo, 16'h0000}) + delta;
    return total[LERP_W-1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] premul(input logic [PROD_W-1:0] prod);
    logic [PROD_W:0]   sum;
    logic [QUOT_W-1:0] q;
    logic [QUOT_W-1:0] rem;
    logic [8:0]        est;
    sum = {1'b0, prod} + PREMUL_BIAS;
    q   = sum[PROD_W:PROD_W-QUOT_W+1];
    est = q[QUOT_W-1:8];
    rem = q - (QUOT_W'(est) << 8) + QUOT_W'(est);
    if (rem >= QUOT_W'(255)) begin
      est = est + 1'b1;
    end
    return est[CHAN_W-1:0];
  endfunction

  assign s8_en = !out_valid_r || out_tready;
  assign s7_en = !s7_valid_r || s8_en;
  assign s6_en = !s6_valid_r || s7_en;
  assign up_en = s6_en;

  always_comb begin
    c_hi      = in_single ? in_c0 : in_c1;
    s6_va_nxt = lerp(in_c0.a, c_hi.a, in_w);
    s6_vr_nxt = lerp(in_c0.r, c_hi.r, in_w);
    s6_vg_nxt = lerp(in_c0.g, c_hi.g, in_w);
    s6_vb_nxt = lerp(in_c0.b, c_hi.b, in_w);
    alpha_sum = s6_va_r + LERP_HALF;
  end

  always_comb begin
    out_data_nxt = {premul(s7_pb_r), premul(s7_pg_r), premul(s7_pr_r), s7_alpha_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r  <= 1'b0;
      s7_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s6_en) begin
        s6_valid_r <= in_valid;
      end
      if (s7_en) begin
        s7_valid_r <= s6_valid_r;
      end
      if (s8_en) begin
        out_valid_r <= s7_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s6_en) begin
      s6_va_r <= s6_va_nxt;
      s6_vr_r <= s6_vr_nxt;
      s6_vg_r <= s6_vg_nxt;
      s6_vb_r <= s6_vb_nxt;
    end
    if (s7_en) begin
      s7_alpha_r <= alpha_sum[LERP_W-1:LERP_W-CHAN_W];
      s7_pr_r    <= PROD_W'(s6_vr_r) * PROD_W'(s6_va_r);
      s7_pg_r    <= PROD_W'(s6_vg_r) * PROD_W'(s6_va_r);
      s7_pb_r    <= PROD_W'(s6_vb_r) * PROD_W'(s6_va_r);
    end
    if (s8_en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/linear_gradient_pixel_shader.sv @@
// ----------------------------------------------------------------------------
// Linear gradient pixel shader
// Throughput: one item per cycle unless a result waits on out_tready, through
// eight register stages with per-stage valid bits; load items write the colour
// table in stage four and give no result.
// Reset: synchronous, active low; clears valid bits and the configuration
// registers. The colour table is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_gradient_pixel_shader
  import lgps_pkg::*;
#(
  parameter int MAX_STOPS      = 16,
  parameter int COORD_BITS     = 12,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [CFG_AW-1:0]                     cfg_addr,
  input  logic [31:0]                           cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // tdata: x_coord, y_coord, stop_index, stop_color, zero fill
  input  logic [((2*COORD_BITS+36+7)/8)*8-1:0]  in_tdata,
  // tuser: mode
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // tdata: pix_alpha, pix_red, pix_green, pix_blue
  output logic [31:0]                           out_tdata
);

  localparam int SW = $clog2(MAX_STOPS);
  localparam int FB = COEF_FRAC_BITS + 1;

  logic signed [COEF_W-1:0] coef_a_r, coef_b_r, coef_c_r;
  logic [1:0]               tile_mode_r;
  logic [4:0]               stop_count_r;
  logic [SW-1:0]            nm1;
  pos_cfg_t                 pos_cfg;
  pipe_tag_t                in_tag, pos_tag;
  stop_load_t               in_load, pos_load;
  logic [FB-1:0]            pos_frac;
  logic                     pos_down_en, stops_down_en;
  logic                     stops_valid, stops_single;
  argb_t                    stops_c0, stops_c1;
  logic [WEIGHT_W-1:0]      stops_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r     <= '0;
      coef_b_r     <= '0;
      coef_c_r     <= '0;
      tile_mode_r  <= TILE_CLAMP;
      stop_count_r <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_COEF_A:     coef_a_r     <= cfg_wdata;
        CFG_COEF_B:     coef_b_r     <= cfg_wdata;
        CFG_COEF_C:     coef_c_r     <= cfg_wdata;
        CFG_TILE_MODE:  tile_mode_r  <= cfg_wdata[1:0];
        CFG_STOP_COUNT: stop_count_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // A stop count of zero counts as one; counts above the table size saturate.
  always_comb begin
    if (stop_count_r == 5'd0) begin
      nm1 = '0;
    end else if (32'(stop_count_r) > 32'(MAX_STOPS)) begin
      nm1 = SW'(MAX_STOPS - 1);
    end else begin
      nm1 = SW'(stop_count_r - 5'd1);
    end
  end

  assign pos_cfg = '{coef_a: coef_a_r, coef_b: coef_b_r, coef_c: coef_c_r,
                     tile_mode: tile_mode_r};

  assign in_tag  = '{valid: in_tvalid, shade: (in_tuser == MODE_SHADE)};
  assign in_load = '{slot:  in_tdata[2*COORD_BITS+SLOT_W-1:2*COORD_BITS],
                     color: in_tdata[2*COORD_BITS+SLOT_W+COLOR_W-1:2*COORD_BITS+SLOT_W]};

  lgps_position #(
    .COORD_BITS     (COORD_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_position (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (pos_cfg),
    .in_tag   (in_tag),
    .in_load  (in_load),
    .x_coord  (in_tdata[COORD_BITS-1:0]),
    .y_coord  (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .up_en    (in_tready),
    .down_en  (pos_down_en),
    .out_tag  (pos_tag),
    .out_load (pos_load),
    .out_frac (pos_frac)
  );

  lgps_stops #(
    .MAX_STOPS      (MAX_STOPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_stops (
    .clk        (clk),
    .rst_n      (rst_n),
    .nm1        (nm1),
    .in_tag     (pos_tag),
    .in_load    (pos_load),
    .in_frac    (pos_frac),
    .up_en      (pos_down_en),
    .down_en    (stops_down_en),
    .out_valid  (stops_valid),
    .out_c0     (stops_c0),
    .out_c1     (stops_c1),
    .out_w      (stops_w),
    .out_single (stops_single)
  );

  lgps_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (stops_valid),
    .in_c0      (stops_c0),
    .in_c1      (stops_c1),
    .in_w       (stops_w),
    .in_single  (stops_single),
    .up_en      (stops_down_en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (!rst_n) !out_tvalid |-> in_tready)
    else $error("Input held off although the output register is empty.");

  assert property (@(posedge clk) disable iff (!rst_n)
                   !in_tready |-> (out_tvalid && !out_tready))
    else $error("Input held off without a stalled result transfer.");

  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Result valid directly after reset.");
`endif

endmodule

`default_nettype wire
